// ===== src/aghp_pkg.sv =====
// ============================================================================
// Adaptive-gain heater PWM package
// Shared widths, register map, reset values and control constants of the
// time-proportional heater controller with adaptive proportional gain.
// ============================================================================
`default_nettype none

package aghp_pkg;

  // Default number of 5 ms ticks in one second.
  localparam int unsigned TICKS_PER_SECOND_DEF = 200;

  // Field widths.
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned RISE_W   = 11;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SEC_W    = 8;

  // Error in tenths of a degree: 10*(offset+setpoint) - temperature.
  localparam int unsigned ERR_W   = 14;
  // Positive part of the error.
  localparam int unsigned ERRP_W  = 13;
  // Limit 10*setpoint, also the width of the clamped drive.
  localparam int unsigned LIM_W   = 12;
  localparam int unsigned DRIVE_W = LIM_W;
  // Error times gain.
  localparam int unsigned GPROD_W = ERRP_W + GAIN_W;

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  // Configuration port.
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_OFFSET    = 3'd1;
  localparam logic [2:0] REG_CYCLE     = 3'd2;
  localparam logic [2:0] REG_INIT_GAIN = 3'd3;
  localparam logic [2:0] REG_FALLBACK  = 3'd4;

  // Register reset values.
  localparam logic [CFG_W-1:0] SETPOINT_RST  = 8'd0;
  localparam logic [CFG_W-1:0] OFFSET_RST    = 8'd0;
  localparam logic [CFG_W-1:0] CYCLE_RST     = 8'd10;
  localparam logic [CFG_W-1:0] INIT_GAIN_RST = 8'd25;
  localparam logic [CFG_W-1:0] FALLBACK_RST  = 8'd20;

  // Gain adaptation thresholds.
  localparam logic signed [ERR_W-1:0]  ERR_BUMP_LO   = 14'sd9;
  localparam logic signed [ERR_W-1:0]  ERR_BUMP_HI   = 14'sd150;
  localparam logic signed [ERR_W-1:0]  ERR_OVERSHOOT = -14'sd3;
  localparam logic signed [RISE_W-1:0] RISE_SLOW     = 11'sd3;
  localparam logic [SEC_W-1:0]         SEC_BUMP      = 8'd20;
  localparam logic [GAIN_W-1:0]        GAIN_STEP     = 8'd2;
  localparam logic [GAIN_W-1:0]        GAIN_SAT_LIM  = 8'd253;
  localparam logic [GAIN_W-1:0]        GAIN_MIN      = 8'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADAPT,
    ST_MUL_GAIN,
    ST_CLAMP,
    ST_MUL_PLEN,
    ST_DIV_SETUP,
    ST_DIV,
    ST_FIN
  } aghp_state_e;

endpackage : aghp_pkg

`default_nettype wire

// ===== src/adaptive_gain_heater_pwm.sv =====
// ============================================================================
// Adaptive-gain heater PWM
// Time-proportional heater control with an adaptive proportional gain, one
// request per 5 ms tick, built around one shared adder and a small sequencer.
// ============================================================================
// Each input request is one tick carrying temperature, rise and enable; each
// tick returns exactly one result with the heater bit, the gain in use and
// the on time of the period in ticks. For an enabled tick with a nonzero
// setpoint, one shared adder runs an 8-step multiply of error by gain, a
// 12-step multiply of drive by period length and a Q-step restoring divide
// by 10*setpoint, where Q is the bit width of 255*TICKS_PER_SECOND (Q = 16
// at the default of 200). A disabled tick goes straight to the finish state
// and an enabled tick with a zero setpoint passes only the adapt state. The
// input is not ready while a tick is in work; the result sits in an output
// register, so the next tick may be taken while it waits. The user must
// write registers through the APB port only while the block is idle; the
// block does not enforce this. Writing initial_gain also reloads the gain.
`default_nettype none

module adaptive_gain_heater_pwm
  import aghp_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input ticks.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [11:0] temperature, [22:12] rise, [23] enable
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // Results.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] heater_on, [8:1] current_gain, [24:9] pulse_ticks, [31:25] zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // Configuration.
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  // Derived sizes.
  localparam int unsigned PLEN_MAX = 255 * TICKS_PER_SECOND;
  localparam int unsigned QUO_W    = $clog2(PLEN_MAX + 1);
  localparam int unsigned PROD_W   = DRIVE_W + QUO_W;
  localparam int unsigned ACC_W    = (PROD_W > GPROD_W) ? PROD_W : GPROD_W;
  localparam int unsigned SUM_W    = ACC_W + 1;
  localparam int unsigned SUB_W    = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int unsigned MAXIT    = (QUO_W > DRIVE_W) ? QUO_W : DRIVE_W;
  localparam int unsigned CNT_W    = $clog2(MAXIT + 1);
  localparam int unsigned QX_W     = (QUO_W > PULSE_W) ? QUO_W : PULSE_W + 1;
  localparam int unsigned CMP_W    = (QUO_W > PULSE_W) ? QUO_W : PULSE_W;
  localparam int unsigned PAD_W    = M_TDATA_W - (1 + GAIN_W + PULSE_W);

  // Configuration registers.
  logic [CFG_W-1:0] setpoint_q, offset_q, cycle_q, init_gain_q, fallback_q;

  // Control state.
  aghp_state_e          state_q, state_d;
  logic                 out_valid_q;
  logic [PERIOD_W-1:0]  period_q;
  logic [SUB_W-1:0]     sub_q;
  logic [SEC_W-1:0]     sec_q;
  logic [GAIN_W-1:0]    gain_q;

  // Datapath registers.
  logic signed [ERR_W-1:0]  err_q;
  logic signed [RISE_W-1:0] rise_q;
  logic                     en_q;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         mcand_q;
  logic [DRIVE_W-1:0]       mplier_q;
  logic [LIM_W-1:0]         rem_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [M_TDATA_W-PAD_W-1:0] out_data_q;

  // Handshake and control strobes.
  logic cfg_wr;
  logic in_ready;
  logic in_acc;
  logic out_load;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Configuration-derived values: limit = 10*setpoint, period length.
  logic [LIM_W-1:0] limit;
  logic [QUO_W-1:0] plen;

  assign limit = (LIM_W'(setpoint_q) << 3) + (LIM_W'(setpoint_q) << 1);
  assign plen  = QUO_W'(32'(cycle_q) * TICKS_PER_SECOND);

  // Error of the incoming tick.
  logic [TEMP_W-1:0]        temp_in;
  logic [RISE_W-1:0]        rise_in;
  logic                     en_in;
  logic [CFG_W:0]           cfg_sum;
  logic [ERR_W-1:0]         cfg_x10;
  logic signed [ERR_W-1:0]  err_in;

  assign temp_in = s_axis_tdata[TEMP_W-1:0];
  assign rise_in = s_axis_tdata[TEMP_W+RISE_W-1:TEMP_W];
  assign en_in   = s_axis_tdata[TEMP_W+RISE_W];
  assign cfg_sum = (CFG_W+1)'(setpoint_q) + (CFG_W+1)'(offset_q);
  assign cfg_x10 = (ERR_W'(cfg_sum) << 3) + (ERR_W'(cfg_sum) << 1);
  assign err_in  = signed'(cfg_x10) - signed'({{(ERR_W-TEMP_W){temp_in[TEMP_W-1]}}, temp_in});

  // Tick and second counters.
  logic [SUB_W:0]      sub_inc;
  logic                sub_wrap;

  assign sub_inc  = (SUB_W+1)'(sub_q) + (SUB_W+1)'(1);
  assign sub_wrap = (sub_inc >= (SUB_W+1)'(TICKS_PER_SECOND));

  // Gain adaptation.
  logic              bump;
  logic [GAIN_W-1:0] gain_up;
  logic [GAIN_W-1:0] gain_ovs;
  logic [GAIN_W-1:0] gain_next;
  logic [ERRP_W-1:0] err_pos;

  assign bump = (err_q > ERR_BUMP_LO) && (err_q < ERR_BUMP_HI) &&
                (rise_q < RISE_SLOW) && (sec_q >= SEC_BUMP);

  always_comb begin
    gain_up = gain_q;
    if (bump) begin
      gain_up = (gain_q > GAIN_SAT_LIM) ? '1 : gain_q + GAIN_STEP;
    end
    gain_ovs  = (err_q < ERR_OVERSHOOT) ? fallback_q : gain_up;
    gain_next = (gain_ovs == '0) ? GAIN_MIN : gain_ovs;
  end

  assign err_pos = (err_q > 0) ? err_q[ERRP_W-1:0] : '0;

  // Shared adder: multiply steps, clamp compare and divide trial subtract.
  logic [SUM_W-1:0] add_a, add_b, sum;
  logic             add_cin;
  logic             sum_neg;
  logic [LIM_W:0]   div_trial;

  assign div_trial = {rem_q, acc_q[QUO_W-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      ST_MUL_GAIN, ST_MUL_PLEN: begin
        add_a = {1'b0, acc_q};
        add_b = mplier_q[0] ? {1'b0, mcand_q} : '0;
      end
      ST_CLAMP: begin
        add_a   = {1'b0, acc_q};
        add_b   = ~SUM_W'(limit);
        add_cin = 1'b1;
      end
      ST_DIV: begin
        add_a   = SUM_W'(div_trial);
        add_b   = ~SUM_W'(limit);
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum     = add_a + add_b + SUM_W'(add_cin);
  assign sum_neg = sum[SUM_W-1];

  // Result of the tick.
  logic [QX_W-1:0]    quo_ext;
  logic [PULSE_W-1:0] pulse;
  logic               heater;
  logic               period_end;

  assign quo_ext    = QX_W'(acc_q[QUO_W-1:0]);
  assign pulse      = (|quo_ext[QX_W-1:PULSE_W]) ? '1 : quo_ext[PULSE_W-1:0];
  assign heater     = en_q && (setpoint_q != '0) && (period_q <= pulse);
  assign period_end = (CMP_W'(period_q) >= CMP_W'(plen));

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = en_in ? ST_ADAPT : ST_FIN;
        end
      end
      ST_ADAPT: begin
        state_d = (setpoint_q == '0) ? ST_FIN : ST_MUL_GAIN;
      end
      ST_MUL_GAIN: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_MUL_PLEN;
      end
      ST_MUL_PLEN: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_DIV_SETUP;
      end
      ST_DIV_SETUP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  end

  assign in_acc        = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  // Control registers: state, counters, gain, configuration, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      period_q    <= '0;
      sub_q       <= '0;
      sec_q       <= '0;
      gain_q      <= INIT_GAIN_RST;
      setpoint_q  <= SETPOINT_RST;
      offset_q    <= OFFSET_RST;
      cycle_q     <= CYCLE_RST;
      init_gain_q <= INIT_GAIN_RST;
      fallback_q  <= FALLBACK_RST;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_SETPOINT:  setpoint_q <= pwdata[CFG_W-1:0];
          REG_OFFSET:    offset_q   <= pwdata[CFG_W-1:0];
          REG_CYCLE:     cycle_q    <= pwdata[CFG_W-1:0];
          REG_INIT_GAIN: begin
            init_gain_q <= pwdata[CFG_W-1:0];
            gain_q      <= pwdata[CFG_W-1:0];
          end
          REG_FALLBACK:  fallback_q <= pwdata[CFG_W-1:0];
          default: begin
          end
        endcase
      end else if (state_q == ST_ADAPT) begin
        gain_q <= gain_next;
      end

      // Tick counters advance on every accepted tick.
      if (in_acc) begin
        period_q <= period_q + PERIOD_W'(1);
        sub_q    <= sub_wrap ? '0 : sub_inc[SUB_W-1:0];
        if (sub_wrap) sec_q <= sec_q + SEC_W'(1);
      end else if (state_q == ST_ADAPT && bump) begin
        sec_q <= '0;
      end

      // Period restarts after the heater decision of an enabled tick that ends it.
      if (out_load && en_q && period_end) begin
        period_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the shared unit.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          err_q  <= err_in;
          rise_q <= signed'(rise_in);
          en_q   <= en_in;
          acc_q  <= '0;
        end
      end
      ST_ADAPT: begin
        acc_q    <= '0;
        mcand_q  <= ACC_W'(err_pos);
        mplier_q <= DRIVE_W'(gain_next);
        cnt_q    <= CNT_W'(GAIN_W);
      end
      ST_MUL_GAIN, ST_MUL_PLEN: begin
        acc_q    <= sum[ACC_W-1:0];
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNT_W'(1);
      end
      ST_CLAMP: begin
        // Drive is the smaller of error*gain and 10*setpoint.
        acc_q    <= '0;
        mcand_q  <= ACC_W'(plen);
        mplier_q <= sum_neg ? acc_q[DRIVE_W-1:0] : limit;
        cnt_q    <= CNT_W'(DRIVE_W);
      end
      ST_DIV_SETUP: begin
        rem_q <= acc_q[PROD_W-1:QUO_W];
        cnt_q <= CNT_W'(QUO_W);
      end
      ST_DIV: begin
        // One restoring step: quotient bit shifts into the accumulator.
        rem_q <= sum_neg ? div_trial[LIM_W-1:0] : sum[LIM_W-1:0];
        acc_q <= {acc_q[ACC_W-2:0], ~sum_neg};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_FIN: begin
        if (out_load) out_data_q <= {pulse, gain_q, heater};
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_data_q};

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_SETPOINT:  prdata = APB_DW'(setpoint_q);
      REG_OFFSET:    prdata = APB_DW'(offset_q);
      REG_CYCLE:     prdata = APB_DW'(cycle_q);
      REG_INIT_GAIN: prdata = APB_DW'(init_gain_q);
      REG_FALLBACK:  prdata = APB_DW'(fallback_q);
      default:       prdata = '0;
    endcase
  end

  // An accepted tick closes the input until its result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a tick was in work");

  // The partial remainder stays below the divisor in every divide step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < limit))
    else $error("divide remainder not below 10*setpoint");

  // Iterating states never run with an exhausted step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_GAIN || state_q == ST_MUL_PLEN || state_q == ST_DIV)
      |-> (cnt_q != '0))
    else $error("iteration count ran out");

  // A finished tick waiting for the output keeps its period count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_load) |=> (state_q == ST_FIN && $stable(period_q)))
    else $error("finished tick lost while output was full");

endmodule : adaptive_gain_heater_pwm

`default_nettype wire

// ===== tb/sv/aghp_tick_checker.sv =====
// ============================================================================
// Adaptive-gain heater PWM tick checker
// Watches the tick and result streams and the register port, keeps its own
// copy of the controller state, predicts every result and compares it.
// ============================================================================
`timescale 1ns / 100ps

module aghp_tick_checker
  import aghp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  // [11:0] temperature, [22:12] rise, [23] enable
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] heater_on, [8:1] current_gain, [24:9] pulse_ticks, [31:25] zero
  input  wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  input  wire logic [APB_DW-1:0]    prdata,
  input  wire logic                 pready,
  output int unsigned               mismatch_count_o,
  output int unsigned               outstanding_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                heater_on;
    logic [GAIN_W-1:0]   gain;
    logic [PULSE_W-1:0]  pulse_ticks;
  } tick_result_t;

  // Shadow registers.
  logic [CFG_W-1:0] setpoint_q;
  logic [CFG_W-1:0] offset_q;
  logic [CFG_W-1:0] cycle_q;
  logic [CFG_W-1:0] init_gain_q;
  logic [CFG_W-1:0] fallback_q;

  // Controller state as the block should hold it.
  logic [PERIOD_W-1:0] period_q;
  int unsigned         subsec_q;
  logic [SEC_W-1:0]    seconds_q;
  logic [GAIN_W-1:0]   gain_q;

  tick_result_t expected_results[$];
  int unsigned  mismatches;

  assign mismatch_count_o = mismatches;

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Advances the shadow state by one tick and returns the result it causes.
  function automatic tick_result_t predict_tick(input logic [S_TDATA_W-1:0] word);
    logic signed [TEMP_W-1:0] temp;
    logic signed [RISE_W-1:0] rise;
    logic                     enable;
    int                       err;
    longint                   drive;
    longint                   limit;
    longint                   period_len;
    longint                   on_ticks;
    tick_result_t             res;
    temp   = word[TEMP_W-1:0];
    rise   = word[TEMP_W+RISE_W-1:TEMP_W];
    enable = word[TEMP_W+RISE_W];
    res    = '0;

    // Free-running counters move on every tick.
    period_q = period_q + PERIOD_W'(1);
    subsec_q++;
    if (subsec_q >= TICKS_PER_SECOND_DEF) begin
      subsec_q  = 0;
      seconds_q = seconds_q + SEC_W'(1);
    end

    if (enable) begin
      err        = 10 * (int'(offset_q) + int'(setpoint_q)) - int'(temp);
      limit      = 10 * longint'(setpoint_q);
      period_len = longint'(cycle_q) * TICKS_PER_SECOND_DEF;

      // Slow rise near the target for long enough raises the gain.
      if (err > int'(ERR_BUMP_LO) && err < int'(ERR_BUMP_HI) &&
          int'(rise) < int'(RISE_SLOW) && seconds_q >= SEC_BUMP) begin
        seconds_q = '0;
        if (gain_q > GAIN_SAT_LIM) gain_q = '1;
        else gain_q = gain_q + GAIN_STEP;
      end
      // Overshoot falls back to the second gain.
      if (err < int'(ERR_OVERSHOOT)) gain_q = fallback_q;
      if (gain_q < GAIN_MIN) gain_q = GAIN_MIN;

      drive = (err > 0) ? longint'(err) * longint'(gain_q) : 0;
      if (drive > limit) drive = limit;

      if (setpoint_q != '0) begin
        on_ticks        = drive * period_len / limit;
        res.pulse_ticks = (on_ticks > 65535) ? '1 : on_ticks[PULSE_W-1:0];
        res.heater_on   = (longint'(period_q) <= longint'(res.pulse_ticks));
      end

      if (longint'(period_q) >= period_len) period_q = '0;
    end

    res.gain = gain_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got;
    tick_result_t want;
    logic [CFG_W-1:0] reg_val;
    logic             mapped;
    if (!rst_ni) begin
      setpoint_q  = SETPOINT_RST;
      offset_q    = OFFSET_RST;
      cycle_q     = CYCLE_RST;
      init_gain_q = INIT_GAIN_RST;
      fallback_q  = FALLBACK_RST;
      period_q    = '0;
      subsec_q    = 0;
      seconds_q   = '0;
      gain_q      = INIT_GAIN_RST;
      mismatches  = 0;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      // Register port: writes update the shadow copy, reads are checked.
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_AW-1:2])
            REG_SETPOINT:  setpoint_q = pwdata[CFG_W-1:0];
            REG_OFFSET:    offset_q   = pwdata[CFG_W-1:0];
            REG_CYCLE:     cycle_q    = pwdata[CFG_W-1:0];
            REG_INIT_GAIN: begin
              init_gain_q = pwdata[CFG_W-1:0];
              gain_q      = pwdata[CFG_W-1:0];
            end
            REG_FALLBACK:  fallback_q = pwdata[CFG_W-1:0];
            default: ;
          endcase
        end else begin
          mapped = 1'b1;
          case (paddr[APB_AW-1:2])
            REG_SETPOINT:  reg_val = setpoint_q;
            REG_OFFSET:    reg_val = offset_q;
            REG_CYCLE:     reg_val = cycle_q;
            REG_INIT_GAIN: reg_val = init_gain_q;
            REG_FALLBACK:  reg_val = fallback_q;
            default: begin
              reg_val = '0;
              mapped  = 1'b0;
            end
          endcase
          if (mapped && prdata !== APB_DW'(reg_val)) begin
            flag_mismatch($sformatf("read of register %0d: expected %0h, got %0h",
                                    paddr[APB_AW-1:2], reg_val, prdata));
          end
        end
      end

      // Result request: compare against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got.heater_on   = m_axis_tdata[0];
        got.gain        = m_axis_tdata[GAIN_W:1];
        got.pulse_ticks = m_axis_tdata[GAIN_W+PULSE_W:GAIN_W+1];
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: %0h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.heater_on !== want.heater_on) begin
            flag_mismatch($sformatf("heater_on: expected %0d, got %0d",
                                    want.heater_on, got.heater_on));
          end
          if (got.gain !== want.gain) begin
            flag_mismatch($sformatf("current_gain: expected %0d, got %0d",
                                    want.gain, got.gain));
          end
          if (got.pulse_ticks !== want.pulse_ticks) begin
            flag_mismatch($sformatf("pulse_ticks: expected %0d, got %0d",
                                    want.pulse_ticks, got.pulse_ticks));
          end
          if (m_axis_tdata[M_TDATA_W-1:GAIN_W+PULSE_W+1] !== '0) begin
            flag_mismatch($sformatf("padding bits: expected 0, got %0h",
                                    m_axis_tdata[M_TDATA_W-1:GAIN_W+PULSE_W+1]));
          end
        end
      end

      // Tick request: predict its result.
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_tick(s_axis_tdata));
      end

      outstanding_o <= expected_results.size();
    end
  end

endmodule : aghp_tick_checker

// ===== tb/sv/tb_adaptive_gain_heater_pwm.sv =====
// ============================================================================
// Adaptive-gain heater PWM testbench
// Drives ticks and register writes into the heater controller: a directed
// pass over field extremes, gain limits and the degenerate settings, then
// random phases under several stall patterns. A separate checker predicts and
// compares every result; this module only makes stimulus and gives a verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb_adaptive_gain_heater_pwm;
  import aghp_pkg::*;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned PHASE_TICKS     = 95;
  // Short runs of disabled ticks that only move the counters.
  localparam int unsigned DISABLED_RUN    = 12;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned ENABLE_PCT      = 85;
  localparam logic [2:0]  REG_UNMAPPED    = 3'd5;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [11:0] temperature, [22:12] rise, [23] enable
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] heater_on, [8:1] current_gain, [24:9] pulse_ticks, [31:25] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [APB_AW-1:0]    paddr         = '0;
  logic [APB_DW-1:0]    pwdata        = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned src_idle_pct = 27;
  int unsigned dst_idle_pct = 59;
  // Setpoint and offset as last written, used to aim the temperature.
  int          cfg_setpoint = int'(SETPOINT_RST);
  int          cfg_offset   = int'(OFFSET_RST);

  adaptive_gain_heater_pwm DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  aghp_tick_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Result side stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #50_000_000;
    $display("FAIL adaptive_gain_heater_pwm");
    $finish;
  end

  function automatic logic [S_TDATA_W-1:0] tick_word(input int temp, input int rise,
                                                      input logic enable);
    logic [TEMP_W-1:0] t;
    logic [RISE_W-1:0] r;
    t = temp[TEMP_W-1:0];
    r = rise[RISE_W-1:0];
    return {enable, r, t};
  endfunction

  // Temperature that gives the wanted error, held inside the field.
  function automatic int temp_for_err(input int err);
    int t;
    t = 10 * (cfg_setpoint + cfg_offset) - err;
    if (t > 2047) t = 2047;
    if (t < -2048) t = -2048;
    return t;
  endfunction

  // Mostly aims at the adaptation and overshoot thresholds, sometimes anywhere.
  function automatic logic [S_TDATA_W-1:0] random_tick();
    int   temp;
    int   rise;
    int   err;
    logic enable;
    case ($urandom_range(9))
      0:       temp = int'($urandom_range(4095)) - 2048;
      1, 2:    temp = int'($urandom_range(2400)) - 400;
      default: begin
        case ($urandom_range(7))
          0:       err = -4;
          1:       err = -3;
          2:       err = 9;
          3:       err = 10;
          4:       err = 149;
          5:       err = 150;
          6:       err = int'($urandom_range(260)) - 60;
          default: err = int'($urandom_range(2000));
        endcase
        temp = temp_for_err(err);
      end
    endcase
    if ($urandom_range(3) == 0) rise = int'($urandom_range(2047)) - 1024;
    else rise = int'($urandom_range(11)) - 5;
    enable = ($urandom_range(99) < ENABLE_PCT);
    return tick_word(temp, rise, enable);
  endfunction

  // Offers one tick and returns once the request is taken.
  task automatic send_tick(input logic [S_TDATA_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  // Disabled ticks with noise in the other fields; they only move counters.
  task automatic send_disabled_run(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_tick(tick_word(int'($urandom_range(4095)), int'($urandom_range(2047)), 1'b0));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // One register access: setup cycle, then access until pready.
  task automatic apb_access(input logic [2:0] idx, input logic wr,
                            input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the registers once the block is idle, then reads them back.
  // Setpoint and cycle get random upper data bits; only the low byte is meant to land.
  task automatic write_config(input int unsigned sp, input int unsigned off,
                              input int unsigned cyc, input int unsigned ig,
                              input int unsigned fb, input logic load_gain);
    end_stream();
    wait_drained();
    apb_access(REG_SETPOINT, 1'b1, {8'($urandom_range(255)), 16'h0, sp[7:0]});
    apb_access(REG_OFFSET, 1'b1, {24'h0, off[7:0]});
    apb_access(REG_CYCLE, 1'b1, {8'($urandom_range(255)), 16'h0, cyc[7:0]});
    if (load_gain) apb_access(REG_INIT_GAIN, 1'b1, {24'h0, ig[7:0]});
    apb_access(REG_FALLBACK, 1'b1, {24'h0, fb[7:0]});
    apb_access(REG_SETPOINT, 1'b0, '0);
    apb_access(REG_OFFSET, 1'b0, '0);
    apb_access(REG_CYCLE, 1'b0, '0);
    apb_access(REG_INIT_GAIN, 1'b0, '0);
    apb_access(REG_FALLBACK, 1'b0, '0);
    cfg_setpoint = int'(sp[7:0]);
    cfg_offset   = int'(off[7:0]);
  endtask

  initial begin
    int unsigned sp;
    int unsigned off;
    int unsigned cyc;
    int unsigned ig;
    int unsigned fb;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero setpoint keeps the heater off, overshoot falls back.
    send_tick(tick_word(0, 0, 1'b0));
    send_tick(tick_word(2047, 1023, 1'b1));
    send_tick(tick_word(-2048, -1024, 1'b1));

    // Zero initial and fallback gain, one second period, threshold edges.
    write_config(40, 2, 1, 0, 0, 1'b1);
    apb_access(REG_UNMAPPED, 1'b1, $urandom);
    send_tick(tick_word(temp_for_err(20), 0, 1'b1));
    send_tick(tick_word(temp_for_err(-4), 0, 1'b1));
    send_tick(tick_word(temp_for_err(-3), 0, 1'b1));
    send_tick(tick_word(temp_for_err(9), 2, 1'b1));
    send_tick(tick_word(temp_for_err(10), 3, 1'b1));
    send_tick(tick_word(temp_for_err(149), -1, 1'b1));
    send_tick(tick_word(temp_for_err(150), 2, 1'b1));
    send_tick(tick_word(-400, -1000, 1'b1));
    send_tick(tick_word(2000, 1000, 1'b1));
    send_tick(tick_word(-1, -1, 1'b1));

    // Zero cycle length: period restarts every tick.
    write_config(40, 2, 0, 7, 3, 1'b0);
    send_tick(tick_word(temp_for_err(100), 0, 1'b1));
    send_tick(tick_word(temp_for_err(5), 0, 1'b1));

    // All registers but the offset at their maximum: drive clamps to the limit.
    write_config(255, 0, 255, 255, 255, 1'b1);
    send_tick(tick_word(-2048, 0, 1'b1));
    send_tick(tick_word(temp_for_err(1), 0, 1'b1));

    // Gain near the top of its range with the fallback at the maximum.
    write_config(180, 0, 2, 254, 255, 1'b1);
    send_disabled_run(DISABLED_RUN);
    send_tick(tick_word(temp_for_err(50), 0, 1'b1));
    send_tick(tick_word(temp_for_err(50), -1024, 1'b1));
    send_tick(tick_word(temp_for_err(50), 0, 1'b1));

    // Random phases under three stall patterns.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin
          src_idle_pct = 27;
          dst_idle_pct = 59;
        end
        1: begin
          src_idle_pct = 59;
          dst_idle_pct = 27;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      case ($urandom_range(5))
        0:       sp = 0;
        1:       sp = 255;
        2:       sp = 1;
        default: sp = $urandom_range(200, 20);
      endcase
      case ($urandom_range(4))
        0:       off = 255;
        1:       off = $urandom_range(20, 1);
        default: off = 0;
      endcase
      case ($urandom_range(5))
        0:       cyc = 0;
        1:       cyc = 255;
        2:       cyc = 1;
        default: cyc = $urandom_range(20, 2);
      endcase
      case ($urandom_range(5))
        0:       ig = 0;
        1:       ig = 255;
        2:       ig = 254;
        default: ig = $urandom_range(60, 1);
      endcase
      case ($urandom_range(4))
        0:       fb = 0;
        1:       fb = 255;
        default: fb = $urandom_range(40, 1);
      endcase
      write_config(sp, off, cyc, ig, fb, $urandom_range(2) != 0);
      if (p % 3 == 1) send_disabled_run(DISABLED_RUN);
      for (int unsigned i = 0; i < PHASE_TICKS; i++) begin
        send_tick(random_tick());
      end
    end
    end_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS adaptive_gain_heater_pwm");
    end else begin
      $display("FAIL adaptive_gain_heater_pwm");
    end
    $finish;
  end

endmodule : tb_adaptive_gain_heater_pwm
